// ----- hdl/prp_pkg.sv -----
// Pager package: sizes, field layout of the page table entry, policy codes.
// No dependencies.
package prp_pkg;
  localparam int PAGE_COUNT = 64;
  localparam int MAX_FRAMES = 64;
  localparam int NRU_CLEAR_PERIOD = 10;
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int EW = 4 + FW;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_CLOCK = 2'd1;
  localparam logic [1:0] POL_NRU   = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  // page entry bits
  localparam int B_P = 0;
  localparam int B_R = 1;
  localparam int B_M = 2;
  localparam int B_O = 3;
endpackage

// ----- hdl/prp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module prp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/page_replacement_pager_core.sv -----
// Pager top level: page table, frame owner and frame queue RAMs under one sequencer; needs prp_pkg,
// prp_ram. Clock skips up to frames_filled+1 referenced frames before its pick. NRU clears R on
// every tenth pick, then scans classes (up to 4), reduces the random value modulo the class size,
// selects the member, searches the queue for its frame and shifts the queue slots behind it.
// One item at a time; ready again the cycle after the result beat unless a config write waits.
// Reset: sync rst sets FIFO, frame limit 16, empty queue; a pass zeroes all 64 page entries.
module page_replacement_pager_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   is_write,
  input  logic [prp_pkg::PW-1:0] page,
  input  logic [30:0]            random_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit,
  output logic                   evicted_valid,
  output logic [5:0]             evicted_page,
  output logic [5:0]             frame,
  output logic                   wrote_back,
  output logic                   paged_in,
  output logic                   zero_filled,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data
);
  import prp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_LOOK = 5'd1, S_LOOK2 = 5'd2,
    S_CLR = 5'd3, S_QRD = 5'd4, S_QRD2 = 5'd5, S_CLK_OWN = 5'd6,
    S_CLK_PG = 5'd7, S_FIFO = 5'd8, S_EVICT = 5'd9, S_MAP = 5'd10,
    S_OUT = 5'd11, S_NCLR = 5'd12, S_NCNT = 5'd13, S_NMOD = 5'd14,
    S_NSEL = 5'd15, S_NFIND = 5'd16, S_NFIND2 = 5'd17, S_NSHIFT = 5'd18,
    S_NSHIFT2 = 5'd19, S_NTAIL = 5'd20, S_CLK_Q = 5'd21, S_MAP2 = 5'd22,
    S_NSHIFT3 = 5'd23, S_CLK_W = 5'd24, S_CLK_R = 5'd25, S_EV_W = 5'd26,
    S_EV_R = 5'd27;

  logic [4:0] state;
  logic [1:0] policy;
  logic [6:0] frames_in_use;

  logic [FW-1:0] qhead;
  logic [CW-1:0] filled;
  logic [3:0] tally;

  logic wr_l;
  logic [PW-1:0] pg_l;
  logic [30:0] rnd_l;
  logic pg_o;
  logic [FW-1:0] fr;
  logic [PW-1:0] evp;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt2;
  logic [PW:0] idx;
  logic [1:0] cls;
  logic [PW:0] found;
  logic [30:0] rem;
  logic [4:0] mstep;
  logic [CW-1:0] limit;
  logic r_ev, r_wb;

  // page table, owner and queue memories
  logic pe_we; logic [PW-1:0] pe_wa, pe_ra; logic [EW-1:0] pe_wd, pe_rd;
  logic ow_we; logic [FW-1:0] ow_wa, ow_ra; logic [PW-1:0] ow_wd, ow_rd;
  logic q_we; logic [FW-1:0] q_wa, q_ra, q_wd, q_rd;
  logic pe_we_next, ow_we_next, q_we_next;
  prp_ram #(.WIDTH(EW), .DEPTH(PAGE_COUNT)) u_pages (.clk, .we(pe_we),
    .waddr(pe_wa), .wdata(pe_wd), .raddr(pe_ra), .rdata(pe_rd));
  prp_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_owner (.clk, .we(ow_we),
    .waddr(ow_wa), .wdata(ow_wd), .raddr(ow_ra), .rdata(ow_rd));
  prp_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_queue (.clk, .we(q_we),
    .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    if (frames_in_use == 7'd0) limit = CW'(1);
    else if (frames_in_use > 7'(MAX_FRAMES)) limit = CW'(MAX_FRAMES);
    else limit = CW'(frames_in_use);
  end

  logic [FW-1:0] qtail;
  assign qtail = qhead + FW'(filled - CW'(1));

  // page entry read back through the registered address and the registered RAM read
  logic scan_m;
  assign scan_m = pe_rd[B_P] && pe_rd[B_R] == cls[1] && pe_rd[B_M] == cls[0];

  logic [EW-1:0] r_clr;
  assign r_clr = pe_rd & ~(EW'(1) << B_R);

  // shift-subtract modulo step: rem becomes rnd_l mod found
  logic [31:0] mtrial;
  assign mtrial = {rem[30:0], rnd_l[5'd30 - mstep]} - 32'(found);

  // write strobes line up with the address and data registered in the same state
  always_comb begin
    pe_we_next = state == S_CLR || (state == S_LOOK2 && pe_rd[B_P]) ||
                 (state == S_CLK_R && pe_rd[B_R]) || state == S_EV_R ||
                 state == S_MAP || (state == S_NCLR && idx >= (PW+1)'(2));
    ow_we_next = (state == S_MAP);
    q_we_next  = (state == S_LOOK2 && !pe_rd[B_P] && filled < limit) ||
                 (state == S_CLK_R && pe_rd[B_R]) || state == S_FIFO ||
                 state == S_NSHIFT3 || state == S_NTAIL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pe_we <= 1'b0;
      ow_we <= 1'b0;
      q_we  <= 1'b0;
    end else begin
      pe_we <= pe_we_next;
      ow_we <= ow_we_next;
      q_we  <= q_we_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      policy <= POL_FIFO;
      frames_in_use <= 7'd16;
      qhead <= '0;
      filled <= '0;
      tally <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          pe_wa <= idx[PW-1:0]; pe_wd <= '0;
          if (idx == (PW+1)'(PAGE_COUNT - 1)) begin
            idx <= '0; state <= S_IDLE;
          end else idx <= idx + (PW+1)'(1);
        end
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_POLICY) policy <= cfg_data[1:0];
            else frames_in_use <= cfg_data;
          end else if (in_valid) begin
            wr_l <= is_write; pg_l <= page; rnd_l <= random_value;
            pe_ra <= page;
            r_ev <= 1'b0; r_wb <= 1'b0;
            evicted_page <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_LOOK2;
        S_LOOK2: begin
          pg_o <= pe_rd[B_O];
          if (pe_rd[B_P]) begin
            pe_wa <= pg_l; pe_wd <= pe_rd | {{(EW-3){1'b0}}, wr_l, 2'b10};
            hit <= 1'b1; evicted_valid <= 1'b0; wrote_back <= 1'b0;
            paged_in <= 1'b0; zero_filled <= 1'b0;
            frame <= 6'(pe_rd[EW-1:4]);
            state <= S_OUT;
          end else if (filled < limit) begin
            fr <= FW'(filled);
            q_wa <= qhead + FW'(filled); q_wd <= FW'(filled);
            filled <= filled + CW'(1);
            state <= S_MAP;
          end else begin
            cnt <= '0;
            if (policy == POL_NRU) begin
              if (tally + 4'd1 >= 4'(NRU_CLEAR_PERIOD)) begin
                tally <= '0; state <= S_NCLR; idx <= '0;
              end else begin
                tally <= tally + 4'd1; state <= S_NCNT; idx <= '0;
                cls <= '0; found <= '0;
              end
            end else state <= S_QRD;
          end
        end
        // queue head read
        S_QRD: begin q_ra <= qhead; state <= S_QRD2; end
        S_QRD2: state <= (policy == POL_CLOCK && cnt <= filled) ? S_CLK_OWN : S_FIFO;
        S_CLK_OWN: begin ow_ra <= q_rd; fr <= q_rd; state <= S_CLK_Q; end
        S_CLK_Q: state <= S_CLK_PG;
        S_CLK_PG: begin pe_ra <= ow_rd; evp <= ow_rd; state <= S_CLK_W; end
        S_CLK_W: state <= S_CLK_R;
        S_CLK_R: begin
          if (!pe_rd[B_R]) state <= S_FIFO;
          else begin
            pe_wa <= evp; pe_wd <= r_clr;
            q_wa <= qhead + FW'(filled); q_wd <= fr;
            qhead <= qhead + FW'(1);
            cnt <= cnt + CW'(1);
            state <= S_QRD;
          end
        end
        S_FIFO: begin
          fr <= q_rd;
          q_wa <= qhead + FW'(filled); q_wd <= q_rd;
          qhead <= qhead + FW'(1);
          ow_ra <= q_rd;
          state <= S_EVICT;
        end
        S_EVICT: state <= S_MAP2;
        S_MAP2: begin
          pe_ra <= ow_rd;
          evp <= ow_rd;
          evicted_page <= 6'(ow_rd);
          r_ev <= 1'b1;
          state <= S_EV_W;
        end
        S_EV_W: state <= S_EV_R;
        // unmap the victim, keep its frame bits, mark swapped if dirty
        S_EV_R: begin
          r_wb <= pe_rd[B_M];
          pe_wa <= evp;
          pe_wd <= {pe_rd[EW-1:4], pe_rd[B_O] | pe_rd[B_M], 3'b000};
          state <= S_MAP;
        end
        S_MAP: begin
          hit <= 1'b0; evicted_valid <= r_ev; wrote_back <= r_wb;
          paged_in <= pg_o; zero_filled <= !pg_o;
          frame <= 6'(fr);
          pe_wa <= pg_l; pe_wd <= {fr, pg_o, wr_l, 2'b11};
          ow_wa <= fr; ow_wd <= pg_l;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        // read entry idx, write back entry idx-2 with R cleared if present
        S_NCLR: begin
          pe_ra <= idx[PW-1:0];
          pe_wa <= idx[PW-1:0] - PW'(2);
          pe_wd <= pe_rd[B_P] ? r_clr : pe_rd;
          if (idx == (PW+1)'(PAGE_COUNT + 1)) begin
            idx <= '0; cls <= '0; found <= '0; state <= S_NCNT;
          end else idx <= idx + (PW+1)'(1);
        end
        // count the lowest non-empty class
        S_NCNT: begin
          if (idx == (PW+1)'(PAGE_COUNT + 2)) begin
            if (found != '0) begin
              rem <= '0; mstep <= '0; state <= S_NMOD;
            end else if (cls == 2'd3) state <= S_QRD;
            else begin cls <= cls + 2'd1; idx <= '0; end
          end else begin
            pe_ra <= idx[PW-1:0];
            if (idx >= (PW+1)'(2) && scan_m) found <= found + (PW+1)'(1);
            idx <= idx + (PW+1)'(1);
          end
        end
        S_NMOD: begin
          if (!mtrial[31]) rem <= mtrial[30:0];
          else rem <= {rem[29:0], rnd_l[5'd30 - mstep]};
          if (mstep == 5'd30) begin idx <= '0; state <= S_NSEL; end
          else mstep <= mstep + 5'd1;
        end
        // walk to the rem-th member of the class
        S_NSEL: begin
          pe_ra <= idx[PW-1:0];
          idx <= idx + (PW+1)'(1);
          if (idx >= (PW+1)'(2) && scan_m) begin
            if (rem == 31'd0) begin
              fr <= pe_rd[EW-1:4]; cnt <= '0; q_ra <= qhead; state <= S_NFIND;
            end else rem <= rem - 31'd1;
          end
        end
        S_NFIND: state <= S_NFIND2;
        S_NFIND2: begin
          if (cnt == filled) state <= S_QRD;
          else if (q_rd == fr) begin
            cnt2 <= cnt; state <= S_NSHIFT;
          end else begin
            cnt <= cnt + CW'(1); q_ra <= qhead + FW'(cnt + CW'(1)); state <= S_NFIND;
          end
        end
        S_NSHIFT: begin
          if (cnt2 + CW'(1) >= filled) state <= S_NTAIL;
          else begin q_ra <= qhead + FW'(cnt2 + CW'(1)); state <= S_NSHIFT2; end
        end
        S_NSHIFT2: state <= S_NSHIFT3;
        S_NSHIFT3: begin
          q_wa <= qhead + FW'(cnt2); q_wd <= q_rd;
          cnt2 <= cnt2 + CW'(1);
          state <= S_NSHIFT;
        end
        S_NTAIL: begin
          q_wa <= qtail; q_wd <= fr;
          ow_ra <= fr;
          state <= S_EVICT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for page_replacement_pager_core: accesses are driven
// over valid/ready, results predicted by an in-bench pager model and compared.
// Depends on prp_pkg and the pager RTL.
module testbench;
  import prp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        is_write;
    logic [5:0]  page;
    logic [30:0] rnd;
  } access_t;

  typedef struct packed {
    logic       hit;
    logic       ev;
    logic [5:0] evp;
    logic [5:0] fr;
    logic       wb;
    logic       pin;
    logic       zf;
  } outcome_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic is_write = 0;
  logic [5:0] page = 0;
  logic [30:0] random_value = 0;
  logic out_valid, out_ready = 0;
  logic hit, evicted_valid, wrote_back, paged_in, zero_filled;
  logic [5:0] evicted_page, frame;
  logic cfg_valid = 0, cfg_ready, cfg_index = 0;
  logic [6:0] cfg_data = 0;

  page_replacement_pager_core DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // pager model state
  logic [1:0] m_policy;
  int unsigned m_frames;
  logic present[64], refd[64], dirty[64], swapped[64];
  logic [5:0] pframe[64];
  logic [5:0] owner[64];
  logic [5:0] fq[64];
  int unsigned qhead, filled, tally;

  access_t  pending[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int hold_off = 0;
  int in_gap = 0;
  bit drain_done = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned qp(input int unsigned k);
    return (qhead + k) % 64;
  endfunction

  function automatic int unsigned take_oldest();
    int unsigned f;
    f = fq[qhead];
    qhead = (qhead + 1) % 64;
    fq[qp(filled - 1)] = 6'(f);
    return f;
  endfunction

  function automatic int unsigned take_clock();
    int unsigned f, pg;
    for (int n = 0; n <= filled; n++) begin
      f = fq[qhead];
      pg = owner[f];
      if (!refd[pg]) break;
      refd[pg] = 1'b0;
      qhead = (qhead + 1) % 64;
      fq[qp(filled - 1)] = 6'(f);
    end
    return take_oldest();
  endfunction

  function automatic int unsigned take_nru(input int unsigned rnd);
    int unsigned cand[64];
    int unsigned found, f, pos, k;
    found = 0;
    tally++;
    if (tally >= NRU_CLEAR_PERIOD) begin
      tally = 0;
      for (int i = 0; i < 64; i++) if (present[i]) refd[i] = 1'b0;
    end
    for (int c = 0; c < 4 && found == 0; c++)
      for (int i = 0; i < 64; i++)
        if (present[i] && refd[i] == c[1] && dirty[i] == c[0]) begin
          cand[found] = pframe[i];
          found++;
        end
    if (found == 0) return take_oldest();
    f = cand[rnd % found];
    pos = 0;
    for (k = 0; k < filled; k++)
      if (fq[qp(k)] == f) begin
        pos = k;
        break;
      end
    if (k == filled) return take_oldest();
    for (k = pos; k + 1 < filled; k++) fq[qp(k)] = fq[qp(k + 1)];
    fq[qp(filled - 1)] = 6'(f);
    return f;
  endfunction

  function automatic outcome_t predict_access(input access_t a);
    outcome_t o;
    int unsigned lim, f, pg, vp;
    o = '0;
    pg = a.page;
    lim = m_frames < 1 ? 1 : (m_frames > 64 ? 64 : m_frames);
    if (present[pg]) begin
      o.hit = 1'b1;
      refd[pg] = 1'b1;
      if (a.is_write) dirty[pg] = 1'b1;
      f = pframe[pg];
    end else begin
      if (filled < lim) begin
        f = filled;
        fq[qp(filled)] = 6'(f);
        filled++;
      end else begin
        if (m_policy == POL_CLOCK) f = take_clock();
        else if (m_policy == POL_NRU) f = take_nru(a.rnd);
        else f = take_oldest();
        vp = owner[f];
        o.ev = 1'b1;
        o.evp = 6'(vp);
        if (dirty[vp]) begin
          o.wb = 1'b1;
          swapped[vp] = 1'b1;
        end
        present[vp] = 1'b0; refd[vp] = 1'b0; dirty[vp] = 1'b0;
      end
      if (swapped[pg]) o.pin = 1'b1; else o.zf = 1'b1;
      present[pg] = 1'b1; refd[pg] = 1'b1; dirty[pg] = a.is_write;
      pframe[pg] = 6'(f);
      owner[f] = 6'(pg);
    end
    o.fr = 6'(f);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_outcomes.push_back(
          predict_access(access_t'{is_write, page, random_value}));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          access_t a;
          a = pending.pop_front();
          in_valid <= 1;
          is_write <= a.is_write;
          page <= a.page;
          random_value <= a.rnd;
          in_gap <= $urandom_range(15) == 0 ? $urandom_range(60, 20) : $urandom_range(2);
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) report("unexpected beat", 1, 0);
        else begin
          outcome_t w;
          w = expected_outcomes.pop_front();
          if (hit !== w.hit) report("hit", hit, w.hit);
          if (evicted_valid !== w.ev) report("evicted_valid", evicted_valid, w.ev);
          if (evicted_page !== w.evp) report("evicted_page", evicted_page, w.evp);
          if (frame !== w.fr) report("frame", frame, w.fr);
          if (wrote_back !== w.wb) report("wrote_back", wrote_back, w.wb);
          if (paged_in !== w.pin) report("paged_in", paged_in, w.pin);
          if (zero_filled !== w.zf) report("zero_filled", zero_filled, w.zf);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 0;
      end else if ($urandom_range(9) == 0) begin
        hold_off <= $urandom_range(4) == 0 ? $urandom_range(40) : $urandom_range(3);
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_POLICY) m_policy = val[1:0];
    else m_frames = int'(val);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || expected_outcomes.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic queue_access(input logic w, input logic [5:0] p, input logic [30:0] r);
    pending.push_back(access_t'{w, p, r});
  endtask

  // mostly a working set slightly larger than the frame count, to force evictions
  task automatic queue_random(input int n, input int span);
    for (int i = 0; i < n; i++)
      queue_access(1'($urandom_range(1)),
                   6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(span)),
                   31'($urandom >> 1));
  endtask

  initial begin
    m_policy = POL_FIFO;
    m_frames = 16;
    qhead = 0; filled = 0; tally = 0;
    for (int i = 0; i < 64; i++) begin
      present[i] = 0; refd[i] = 0; dirty[i] = 0; swapped[i] = 0;
      pframe[i] = 0; owner[i] = 0; fq[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed: tiny frame count, writes, rewrites, page extremes, max random
    write_reg(REG_FRAMES, 7'd2);
    queue_access(1, 6'd0, 31'h7fffffff);
    queue_access(0, 6'd63, 31'd0);
    queue_access(1, 6'd0, 31'd5);
    queue_access(0, 6'd5, 31'd1);
    queue_access(0, 6'd0, 31'd2);
    queue_access(1, 6'd63, 31'h7fffffff);
    queue_access(0, 6'd7, 31'd3);
    queue_access(0, 6'd0, 31'd0);
    wait_idle();
    write_reg(REG_POLICY, 7'(POL_CLOCK));
    queue_random(8, 4);
    wait_idle();
    write_reg(REG_POLICY, 7'(POL_NRU));
    queue_random(8, 4);
    wait_idle();
    write_reg(REG_POLICY, 7'd3);
    write_reg(REG_FRAMES, 7'd0);
    queue_random(5, 4);
    wait_idle();
    // long receiver stall while items keep coming
    write_reg(REG_POLICY, 7'(POL_FIFO));
    write_reg(REG_FRAMES, 7'd127);
    queue_random(60, 63);
    @(negedge clk);
    hold_off = 3000;
    wait_idle();
    for (int ph = 0; ph < 9; ph++) begin
      int f;
      f = ph == 0 ? 64 : (ph == 1 ? 1 : $urandom_range(2, 40));
      write_reg(REG_POLICY, 7'(ph % 3));
      write_reg(REG_FRAMES, 7'(f));
      queue_random(55, f + 4 > 63 ? 63 : f + 4);
      wait_idle();
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ----- page_replacement_pager_core.f -----
hdl/prp_pkg.sv
hdl/prp_ram.sv
hdl/page_replacement_pager_core.sv
test/testbench.sv
